>>> src/lfpi_pkg.sv
// Shared constants and register index codes for the line follower PI drive.
package lfpi_pkg;

    // Default fraction bits of the gain registers
    localparam int GAIN_FRAC_BITS_DEF = 8;

    // Field widths
    localparam int GAIN_W   = 12;
    localparam int LIMIT_W  = 7;
    localparam int INTEG_W  = 8;
    localparam int DRIVE_W  = 10;
    localparam int PWM_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Register reset values
    localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST  = 12'sd256;
    localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST = 12'sd0;
    localparam logic [LIMIT_W-1:0]       INTEG_LIMIT_RST = 7'd10;

    // Drive saturation bound, 1.0 in Q8
    localparam int DRIVE_ONE = 256;
    // Full duty
    localparam logic [PWM_W-1:0] PWM_FULL = 8'd255;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN   = 2'd0,
        CFG_INTEG_GAIN  = 2'd1,
        CFG_INTEG_LIMIT = 2'd2
    } cfg_idx_t;

endpackage

>>> src/line_follow_pi_drive.sv
// Line follower PI steering controller: sensor error, clamped integral, drive and PWM duties.
//
// One sensor sample (s_left_sensor, s_right_sensor) is taken per cycle while s_ready is high;
// the result item appears on the m_ channel in the cycle after its sample is accepted. All
// the work - error decode, integral update with saturation to +/-integ_limit, the 12x8
// integral product, the proportional term, Q8 scaling, clamping to +/-256 and the reduced
// duty - sits in one combinational pass between the sample handshake and the result register,
// so the block sustains one item per cycle while m_ready is high. The single result register
// is the only storage on the output side: a new item is accepted whenever that register is
// empty or is being drained in the same cycle, so a stalled m_ready stalls s_ready. The error
// integral is the only controller state and updates at each accepted item. Configuration
// (cfg_wr_en, cfg_index, cfg_wdata) writes prop_gain (index 0), integ_gain (index 1) or
// integ_limit (index 2) at once, and is meant to be used only while no item is in flight. The
// gains carry GAIN_FRAC_BITS fraction bits; results are brought to Q8 by an exact left shift
// or a flooring right shift.
module line_follow_pi_drive #(
    parameter int GAIN_FRAC_BITS = lfpi_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [lfpi_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lfpi_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // sensor sample channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_left_sensor,
    input  logic                                  s_right_sensor,
    // result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [1:0]                     m_line_error,
    output logic                                  m_both_fault,
    output logic signed [lfpi_pkg::INTEG_W-1:0]   m_integral_now,
    output logic signed [lfpi_pkg::DRIVE_W-1:0]   m_drive_value,
    output logic [lfpi_pkg::PWM_W-1:0]            m_left_pwm,
    output logic [lfpi_pkg::PWM_W-1:0]            m_right_pwm
);

    // Q8 alignment of the gain product sum
    localparam int UP_SH  = (GAIN_FRAC_BITS < 8) ? (8 - GAIN_FRAC_BITS) : 0;
    localparam int DN_SH  = (GAIN_FRAC_BITS > 8) ? (GAIN_FRAC_BITS - 8) : 0;
    localparam int PROD_W = lfpi_pkg::GAIN_W + lfpi_pkg::INTEG_W;   // 20
    localparam int RAW_W  = PROD_W + 1;                             // 21
    localparam int Q8_W   = RAW_W + UP_SH;

    localparam logic signed [Q8_W-1:0] DRV_MAX = Q8_W'(lfpi_pkg::DRIVE_ONE);
    localparam logic signed [Q8_W-1:0] DRV_MIN = -DRV_MAX;

    // configuration registers
    logic signed [lfpi_pkg::GAIN_W-1:0]  prop_gain_reg;
    logic signed [lfpi_pkg::GAIN_W-1:0]  integ_gain_reg;
    logic [lfpi_pkg::LIMIT_W-1:0]        integ_limit_reg;

    // controller state
    logic signed [lfpi_pkg::INTEG_W-1:0] integral_reg;

    // result register
    logic                                m_valid_reg;
    logic signed [1:0]                   line_error_reg;
    logic                                both_fault_reg;
    logic signed [lfpi_pkg::INTEG_W-1:0] integral_now_reg;
    logic signed [lfpi_pkg::DRIVE_W-1:0] drive_value_reg;
    logic [lfpi_pkg::PWM_W-1:0]          left_pwm_reg;
    logic [lfpi_pkg::PWM_W-1:0]          right_pwm_reg;

    // datapath
    logic                                s_accept;
    logic                                err_pos;
    logic                                err_neg;
    logic                                fault;
    logic signed [1:0]                   err;
    logic signed [lfpi_pkg::INTEG_W:0]   isum;
    logic signed [lfpi_pkg::INTEG_W:0]   lim_pos;
    logic signed [lfpi_pkg::INTEG_W:0]   lim_neg;
    logic signed [lfpi_pkg::INTEG_W:0]   iclamp;
    logic signed [lfpi_pkg::INTEG_W-1:0] integral_next;
    logic signed [lfpi_pkg::GAIN_W:0]    p_term;
    logic signed [PROD_W-1:0]            i_prod;
    logic signed [RAW_W-1:0]             raw_sum;
    logic signed [Q8_W-1:0]              raw_ext;
    logic signed [Q8_W-1:0]              q8_val;
    logic signed [lfpi_pkg::DRIVE_W-1:0] drive_next;
    logic signed [lfpi_pkg::DRIVE_W-1:0] drive_neg;
    logic [lfpi_pkg::DRIVE_W-2:0]        mag;
    logic [lfpi_pkg::DRIVE_W-2:0]        rem;
    logic [16:0]                         duty_prod;
    logic [lfpi_pkg::PWM_W-1:0]          reduced;
    logic [lfpi_pkg::PWM_W-1:0]          left_pwm_next;
    logic [lfpi_pkg::PWM_W-1:0]          right_pwm_next;

    // Output register empty or draining this cycle
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    // Sensor decode: both on is a fault and counts as straight
    assign fault   = s_left_sensor && s_right_sensor;
    assign err_pos = s_right_sensor && !s_left_sensor;
    assign err_neg = s_left_sensor && !s_right_sensor;
    assign err     = err_pos ? 2'sb01 : (err_neg ? 2'sb11 : 2'sb00);

    // Integral update, clamped to the current limit
    always_comb begin
        isum    = {integral_reg[lfpi_pkg::INTEG_W-1], integral_reg}
                  + {{(lfpi_pkg::INTEG_W - 1){err[1]}}, err};
        lim_pos = {2'b00, integ_limit_reg};
        lim_neg = -lim_pos;
        iclamp  = isum;
        if (iclamp > lim_pos) begin
            iclamp = lim_pos;
        end
        if (iclamp < lim_neg) begin
            iclamp = lim_neg;
        end
        integral_next = iclamp[lfpi_pkg::INTEG_W-1:0];
    end

    // Gain terms: proportional is a signed select, integral one 12x8 multiply
    always_comb begin
        if (err_pos) begin
            p_term = {prop_gain_reg[lfpi_pkg::GAIN_W-1], prop_gain_reg};
        end else if (err_neg) begin
            p_term = -{prop_gain_reg[lfpi_pkg::GAIN_W-1], prop_gain_reg};
        end else begin
            p_term = '0;
        end
        i_prod  = PROD_W'(integ_gain_reg) * PROD_W'(integral_next);
        raw_sum = RAW_W'(p_term) - RAW_W'(i_prod);
        // exact left shift or flooring arithmetic right shift into Q8
        raw_ext = Q8_W'(raw_sum);
        q8_val  = (raw_ext <<< UP_SH) >>> DN_SH;
    end

    // Drive clamp to +/-1.0 and duty of the slowed side
    always_comb begin
        if (q8_val > DRV_MAX) begin
            drive_next = lfpi_pkg::DRIVE_W'(DRV_MAX);
        end else if (q8_val < DRV_MIN) begin
            drive_next = lfpi_pkg::DRIVE_W'(DRV_MIN);
        end else begin
            drive_next = q8_val[lfpi_pkg::DRIVE_W-1:0];
        end
        drive_neg = -drive_next;
        mag = drive_next[lfpi_pkg::DRIVE_W-1] ? drive_neg[lfpi_pkg::DRIVE_W-2:0]
                                              : drive_next[lfpi_pkg::DRIVE_W-2:0];
        rem = 9'd256 - mag;
        // 255*rem = 256*rem - rem, then floor divide by 256
        duty_prod = {rem, 8'b0} - {8'b0, rem};
        reduced   = duty_prod[15:8];
        left_pwm_next  = lfpi_pkg::PWM_FULL;
        right_pwm_next = lfpi_pkg::PWM_FULL;
        if (drive_next < 0) begin
            left_pwm_next = reduced;
        end else if (drive_next > 0) begin
            right_pwm_next = reduced;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg   <= lfpi_pkg::PROP_GAIN_RST;
            integ_gain_reg  <= lfpi_pkg::INTEG_GAIN_RST;
            integ_limit_reg <= lfpi_pkg::INTEG_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (lfpi_pkg::cfg_idx_t'(cfg_index))
                lfpi_pkg::CFG_PROP_GAIN:   prop_gain_reg   <= $signed(cfg_wdata);
                lfpi_pkg::CFG_INTEG_GAIN:  integ_gain_reg  <= $signed(cfg_wdata);
                lfpi_pkg::CFG_INTEG_LIMIT: integ_limit_reg <= cfg_wdata[lfpi_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Integral state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                integral_reg <= integral_next;
            end
            if (s_accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            line_error_reg   <= err;
            both_fault_reg   <= fault;
            integral_now_reg <= integral_next;
            drive_value_reg  <= drive_next;
            left_pwm_reg     <= left_pwm_next;
            right_pwm_reg    <= right_pwm_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_line_error   = line_error_reg;
    assign m_both_fault   = both_fault_reg;
    assign m_integral_now = integral_now_reg;
    assign m_drive_value  = drive_value_reg;
    assign m_left_pwm     = left_pwm_reg;
    assign m_right_pwm    = right_pwm_reg;

    // The integral never reaches -128: bound is at most 127
    a_integ_range: assert property (@(posedge aclk) disable iff (!aresetn)
        integral_reg != 8'sh80)
        else $error("integral out of range");

    // A fault sample leaves the integral untouched unless it was outside the limit
    a_fault_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && fault && !cfg_wr_en
            && $signed({integral_reg[lfpi_pkg::INTEG_W-1], integral_reg})
               <= $signed({2'b00, integ_limit_reg})
            && $signed({integral_reg[lfpi_pkg::INTEG_W-1], integral_reg})
               >= -$signed({2'b00, integ_limit_reg}))
        |=> $stable(integral_reg))
        else $error("fault sample changed the integral");

    // Only one side is ever slowed
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (left_pwm_reg == lfpi_pkg::PWM_FULL
                         || right_pwm_reg == lfpi_pkg::PWM_FULL))
        else $error("both motors slowed");

    // Drive stays within +/-1.0
    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (drive_value_reg <= 10'sd256 && drive_value_reg >= -10'sd256))
        else $error("drive out of range");

endmodule
